// ----- rtl/core/wrac_pkg.sv -----
// Shared types and constants for the windowed return autocorrelation block.
package wrac_pkg;

  // Fixed field widths of the streaming and register interfaces.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int LAG_W       = 6;
  localparam int RHO_W       = 16;
  localparam int TAU_W       = 6;
  localparam int KIND_W      = 2;
  localparam int OUT_PAD_W   = OUT_TDATA_W - LAG_W - RHO_W - TAU_W;
  localparam int WIN_W       = 11;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RST   = 11'd200;
  localparam logic [LAG_W-1:0] MAX_LAGS_RST = 6'd10;

  // Register select bit of the byte address and its codes.
  localparam int   REG_SEL_BIT  = 2;
  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_MAX_LAGS = 1'b1;

  // Quotient format: Q1.15 magnitude with one saturation code.
  localparam int                Q_W       = 16;
  localparam int                QF_BITS   = 15;
  localparam int                QC_W      = 4;
  localparam logic [Q_W-1:0]    Q_SAT     = 16'h8000;
  localparam logic [RHO_W-1:0]  RHO_MAX   = 16'h7FFF;
  localparam logic signed [RHO_W-1:0] INV_E_Q15 = 16'sd12054;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_RHO   = 2'd0,
    KIND_TAU   = 2'd1,
    KIND_SHORT = 2'd2,
    KIND_FLAT  = 2'd3
  } kind_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;   // clear the accumulator
    logic load;  // latch new operand magnitudes and sign
    logic step;  // add or subtract one partial product
  } mac_ctl_t;

endpackage

// ----- rtl/core/wrac_mac.sv -----
// Shared multiply-accumulate unit: one signed product in four partial-product beats.
module wrac_mac #(
  parameter int MAG_W = 36,
  parameter int ACC_W = 85
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wrac_pkg::mac_ctl_t      ctl,
  input  logic [MAG_W-1:0]        a_mag,
  input  logic [MAG_W-1:0]        b_mag,
  input  logic                    neg,
  output logic signed [ACC_W-1:0] acc,
  output logic                    last_step
);
  import wrac_pkg::*;

  localparam int H = (MAG_W + 1) / 2;

  logic [2*H-1:0]          a_r, b_r;
  logic                    neg_r;
  logic [1:0]              idx_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [H-1:0]            op_a, op_b;
  logic [2*H-1:0]          pp;
  logic signed [ACC_W-1:0] pp_ext;

  // Pick the halves for this beat and place the partial product.
  always_comb begin
    case (idx_r)
      2'd0: begin
        op_a   = a_r[H-1:0];
        op_b   = b_r[H-1:0];
      end
      2'd1: begin
        op_a   = a_r[H-1:0];
        op_b   = b_r[2*H-1:H];
      end
      2'd2: begin
        op_a   = a_r[2*H-1:H];
        op_b   = b_r[H-1:0];
      end
      default: begin
        op_a   = a_r[2*H-1:H];
        op_b   = b_r[2*H-1:H];
      end
    endcase
    pp = op_a * op_b;
    case (idx_r)
      2'd0:    pp_ext = ACC_W'(pp);
      2'd1:    pp_ext = ACC_W'(pp) << H;
      2'd2:    pp_ext = ACC_W'(pp) << H;
      default: pp_ext = ACC_W'(pp) << (2 * H);
    endcase
  end

  // Beat counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctl.load) begin
      idx_r <= '0;
    end else if (ctl.step) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= (2*H)'(a_mag);
      b_r   <= (2*H)'(b_mag);
      neg_r <= neg;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= neg_r ? acc_r - pp_ext : acc_r + pp_ext;
    end
  end

  assign acc       = acc_r;
  assign last_step = (idx_r == 2'd3);

endmodule

// ----- rtl/core/windowed_return_autocorrelation.sv -----
// Top level of the windowed return autocorrelation block.
//
// Usage: each beat on the in_ stream carries one closing price. The block
// appends it to a price history, forms the returns of the current window,
// and emits one result beat per lag 1..max_lags with rho in Q1.15, then a
// summary beat with tau and tlast set. Too few samples or flat returns give
// a single beat with tlast set. out_tuser carries the result kind.
// Registers window_bars (address 0) and max_lags (address 4) sit on the
// cfg_ port and should be written while the block is idle.
// Timing: one price at a time; in_tready is high only in the idle state.
// Each product of two deviations runs through the shared 4-beat
// multiply-accumulate unit; the variance pass forms one per return and
// each lag one per pair of returns that lag apart, then scales the sums
// and divides bit by bit; a lag whose rho saturates skips the division.
// Short cases end at the size check, flat returns after the variance pass.
// When the receiver stalls, the sequencer holds at the next result beat.
// Reset clears the pointers, counts and registers; the history memory is
// not cleared, since only written entries are ever read.
module windowed_return_autocorrelation #(
  parameter int MAX_RETURNS   = 2048,
  parameter int MAX_LAG_LIMIT = 63,
  parameter int PRICE_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream, tdata: close_price [23:0].
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wrac_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result stream, tdata: lag [5:0], rho [21:6], tau [27:22], zero [31:28].
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wrac_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: kind [1:0].
  output logic [wrac_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast,
  // Register port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wrac_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [wrac_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [wrac_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import wrac_pkg::*;

  localparam int HIST_DEPTH = MAX_RETURNS + 1;
  localparam int HA_W    = $clog2(HIST_DEPTH);
  localparam int DA_W    = $clog2(MAX_RETURNS);
  localparam int NB      = $clog2(MAX_RETURNS + 1);
  localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > WIN_W + 1) ? CNT_W : WIN_W + 1;
  localparam int SB_W    = $clog2(NB);
  localparam int EXT_W   = (PRICE_BITS > IN_TDATA_W) ? PRICE_BITS : IN_TDATA_W;
  localparam int MAG_W   = PRICE_BITS + NB;
  localparam int DEV_W   = MAG_W + 1;
  localparam int ACC_W   = 2 * MAG_W + NB + 1;
  localparam int PROD_W  = ACC_W - 1 + NB;
  localparam int REM_W   = PROD_W + 1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_CHECK = 15'h0002,
    S_SUM   = 15'h0004,
    S_RET   = 15'h0008,
    S_DEV   = 15'h0010,
    S_MUL   = 15'h0020,
    S_VCHK  = 15'h0040,
    S_CRD   = 15'h0080,
    S_CLD   = 15'h0100,
    S_NUM   = 15'h0200,
    S_SCALE = 15'h0400,
    S_DIV0  = 15'h0800,
    S_DIV   = 15'h1000,
    S_RHO   = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [HA_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [HA_W-1:0]     rd_pos_r, rd_pos_nxt;
  logic [NB-1:0]       k_r, k_nxt;
  logic [LAG_W-1:0]    lag_r, lag_nxt;
  logic                var_ph_r, var_ph_nxt;
  logic [SB_W-1:0]     sbit_r, sbit_nxt;
  logic [QC_W-1:0]     qc_r, qc_nxt;
  logic [TAU_W-1:0]    tau_r, tau_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]    window_r;
  logic [LAG_W-1:0]    max_lags_r;

  // Data path registers.
  logic [PRICE_BITS-1:0]    p0_r, p0_nxt;
  logic [PRICE_BITS-1:0]    prev_r, prev_nxt;
  logic signed [PRICE_BITS:0] sum_r, sum_nxt;
  logic signed [DEV_W-1:0]  nr_r, nr_nxt;
  logic [NB-1:0]            n_r, n_nxt;
  logic [NB-1:0]            cnt_lag_r, cnt_lag_nxt;
  logic [LAG_W-1:0]         lmax_r, lmax_nxt;
  logic [ACC_W-2:0]         var_r, var_nxt;
  logic [ACC_W-2:0]         cmag_r, cmag_nxt;
  logic                     cneg_r, cneg_nxt;
  logic [PROD_W-1:0]        num_r, num_nxt;
  logic [PROD_W-1:0]        den_r, den_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [Q_W-1:0]           q_r, q_nxt;
  kind_t                    fin_kind_r, fin_kind_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  kind_t                    out_kind_r, out_kind_nxt;
  logic                     out_last_r, out_last_nxt;

  // Memories.
  logic [PRICE_BITS-1:0]    hist_mem [HIST_DEPTH];
  logic [PRICE_BITS-1:0]    hist_q_r;
  logic                     hist_we, hist_re;
  logic signed [DEV_W-1:0]  dev_mem [MAX_RETURNS];
  logic signed [DEV_W-1:0]  dev_a_q_r, dev_b_q_r;
  logic                     dev_we, dev_re;
  logic [NB-1:0]            kb;

  // Shared unit.
  mac_ctl_t                 mac_ctl;
  logic [MAG_W-1:0]         mac_a, mac_b;
  logic                     mac_neg;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_last;

  // Combinational helpers.
  logic                     in_beat, out_free, cfg_wr;
  logic [EXT_W-1:0]         in_ext;
  logic [CMP_W-1:0]         n_full, win1, n1, n2;
  logic [LAG_W-1:0]         lmax_c;
  logic                     too_short;
  logic [HA_W:0]            start_t;
  logic [HA_W-1:0]          start_pos, rd_pos_inc;
  logic signed [PRICE_BITS:0] ret;
  logic signed [NB+PRICE_BITS+1:0] nr_full;
  logic signed [DEV_W-1:0]  dev_v;
  logic [DEV_W-1:0]         dev_abs, dev_a_abs, dev_b_abs;
  logic [ACC_W-1:0]         acc_abs;
  logic [NB-1:0]            k_inc;
  logic [REM_W-1:0]         rem2, den_ext;
  logic                     rem_ge;
  logic [RHO_W-1:0]         rho_v;

  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_ext   = EXT_W'(in_tdata);

  // Window length and start of the return walk.
  always_comb begin
    n_full = CMP_W'(cnt_r) - CMP_W'(1);
    win1   = CMP_W'(window_r) + CMP_W'(1);
    n1     = (n_full > win1) ? win1 : n_full;
    n2     = (n1 > CMP_W'(MAX_RETURNS)) ? CMP_W'(MAX_RETURNS) : n1;
    lmax_c = (max_lags_r > LAG_W'(MAX_LAG_LIMIT)) ? LAG_W'(MAX_LAG_LIMIT) : max_lags_r;
    too_short = (cnt_r < CNT_W'(4)) || (n2 < CMP_W'(lmax_c) + CMP_W'(2));
    start_t   = (HA_W+1)'(wp_r) + (HA_W+1)'(HIST_DEPTH - 1) - (HA_W+1)'(n2);
    start_pos = (start_t >= (HA_W+1)'(HIST_DEPTH)) ?
                HA_W'(start_t - (HA_W+1)'(HIST_DEPTH)) : HA_W'(start_t);
    rd_pos_inc = (rd_pos_r == HA_W'(HIST_DEPTH - 1)) ? '0 : rd_pos_r + HA_W'(1);
  end

  // Returns, deviations and magnitudes.
  always_comb begin
    ret     = $signed({1'b0, hist_q_r}) - $signed({1'b0, prev_r});
    nr_full = $signed({1'b0, n_r}) * ret;
    dev_v   = nr_r - DEV_W'(sum_r);
    dev_abs   = dev_v[DEV_W-1] ? DEV_W'(-dev_v) : DEV_W'(dev_v);
    dev_a_abs = dev_a_q_r[DEV_W-1] ? DEV_W'(-dev_a_q_r) : DEV_W'(dev_a_q_r);
    dev_b_abs = dev_b_q_r[DEV_W-1] ? DEV_W'(-dev_b_q_r) : DEV_W'(dev_b_q_r);
    acc_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    k_inc     = k_r + NB'(1);
    kb        = k_r - NB'(lag_r);
    rem2      = {rem_r[REM_W-2:0], 1'b0};
    den_ext   = REM_W'(den_r);
    rem_ge    = (rem2 >= den_ext);
    if (cneg_r) begin
      rho_v = ~q_r + RHO_W'(1);
    end else begin
      rho_v = q_r[Q_W-1] ? RHO_MAX : q_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    rd_pos_nxt    = rd_pos_r;
    k_nxt         = k_r;
    lag_nxt       = lag_r;
    var_ph_nxt    = var_ph_r;
    sbit_nxt      = sbit_r;
    qc_nxt        = qc_r;
    tau_nxt       = tau_r;
    p0_nxt        = p0_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    nr_nxt        = nr_r;
    n_nxt         = n_r;
    cnt_lag_nxt   = cnt_lag_r;
    lmax_nxt      = lmax_r;
    var_nxt       = var_r;
    cmag_nxt      = cmag_r;
    cneg_nxt      = cneg_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    fin_kind_nxt  = fin_kind_r;
    out_tdata_nxt = out_tdata_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    dev_we        = 1'b0;
    dev_re        = 1'b0;
    mac_ctl       = '0;
    mac_a         = dev_abs[MAG_W-1:0];
    mac_b         = dev_abs[MAG_W-1:0];
    mac_neg       = 1'b0;

    case (state_r)
      // Store the price and advance the history pointers.
      S_IDLE: begin
        if (in_beat) begin
          hist_we = 1'b1;
          p0_nxt  = in_ext[PRICE_BITS-1:0];
          wp_nxt  = (wp_r == HA_W'(HIST_DEPTH - 1)) ? '0 : wp_r + HA_W'(1);
          if (cnt_r < CNT_W'(HIST_DEPTH)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          tau_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      // Size the window and fetch the oldest price of it.
      S_CHECK: begin
        n_nxt    = NB'(n2);
        lmax_nxt = lmax_c;
        if (too_short) begin
          fin_kind_nxt = KIND_SHORT;
          state_nxt    = S_FIN;
        end else begin
          rd_pos_nxt = start_pos;
          hist_re    = 1'b1;
          state_nxt  = S_SUM;
        end
      end
      // Sum of returns is newest minus oldest price.
      S_SUM: begin
        prev_nxt    = hist_q_r;
        sum_nxt     = $signed({1'b0, p0_r}) - $signed({1'b0, hist_q_r});
        rd_pos_nxt  = rd_pos_inc;
        hist_re     = 1'b1;
        k_nxt       = '0;
        var_ph_nxt  = 1'b1;
        mac_ctl.clr = 1'b1;
        state_nxt   = S_RET;
      end
      S_RET: begin
        prev_nxt   = hist_q_r;
        nr_nxt     = nr_full[DEV_W-1:0];
        rd_pos_nxt = rd_pos_inc;
        state_nxt  = S_DEV;
      end
      // Store the scaled deviation and square it.
      S_DEV: begin
        dev_we       = 1'b1;
        hist_re      = 1'b1;
        mac_ctl.load = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        mac_ctl.step = 1'b1;
        if (mac_last) begin
          k_nxt = k_inc;
          if (k_inc == n_r) begin
            state_nxt = var_ph_r ? S_VCHK : S_NUM;
          end else begin
            state_nxt = var_ph_r ? S_RET : S_CRD;
          end
        end
      end
      // Variance done: flat returns, and a max_lags of zero, end here.
      S_VCHK: begin
        var_nxt    = acc[ACC_W-2:0];
        var_ph_nxt = 1'b0;
        if (acc == '0) begin
          fin_kind_nxt = KIND_FLAT;
          state_nxt    = S_FIN;
        end else if (lmax_r == '0) begin
          fin_kind_nxt = KIND_TAU;
          state_nxt    = S_FIN;
        end else begin
          lag_nxt     = LAG_W'(1);
          k_nxt       = NB'(1);
          mac_ctl.clr = 1'b1;
          state_nxt   = S_CRD;
        end
      end
      S_CRD: begin
        dev_re    = 1'b1;
        state_nxt = S_CLD;
      end
      S_CLD: begin
        mac_a        = dev_a_abs[MAG_W-1:0];
        mac_b        = dev_b_abs[MAG_W-1:0];
        mac_neg      = dev_a_q_r[DEV_W-1] ^ dev_b_q_r[DEV_W-1];
        mac_ctl.load = 1'b1;
        state_nxt    = S_MUL;
      end
      // Covariance done: scale numerator by n and denominator by n - lag.
      S_NUM: begin
        cneg_nxt    = acc[ACC_W-1];
        cmag_nxt    = acc_abs[ACC_W-2:0];
        cnt_lag_nxt = n_r - NB'(lag_r);
        num_nxt     = '0;
        den_nxt     = '0;
        sbit_nxt    = SB_W'(NB - 1);
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        num_nxt = {num_r[PROD_W-2:0], 1'b0} + (n_r[sbit_r] ? PROD_W'(cmag_r) : '0);
        den_nxt = {den_r[PROD_W-2:0], 1'b0} + (cnt_lag_r[sbit_r] ? PROD_W'(var_r) : '0);
        if (sbit_r == '0) begin
          state_nxt = S_DIV0;
        end else begin
          sbit_nxt = sbit_r - SB_W'(1);
        end
      end
      // Ratio of one or more saturates; otherwise restoring division.
      S_DIV0: begin
        if (den_r <= num_r) begin
          q_nxt     = Q_SAT;
          state_nxt = S_RHO;
        end else begin
          rem_nxt   = REM_W'(num_r);
          q_nxt     = '0;
          qc_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem2 - den_ext : rem2;
        q_nxt   = {q_r[Q_W-2:0], rem_ge};
        qc_nxt  = qc_r + QC_W'(1);
        if (qc_r == QC_W'(QF_BITS - 1)) begin
          state_nxt = S_RHO;
        end
      end
      // Emit the rho beat and move to the next lag, or to the closing beat after the last.
      S_RHO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RHO;
          out_last_nxt  = 1'b0;
          out_tdata_nxt = {OUT_PAD_W'(0), TAU_W'(0), rho_v, lag_r};
          if (tau_r == '0 && $signed(rho_v) <= INV_E_Q15) begin
            tau_nxt = lag_r;
          end
          if (lag_r == lmax_r) begin
            fin_kind_nxt = KIND_TAU;
            state_nxt    = S_FIN;
          end else begin
            lag_nxt     = lag_r + LAG_W'(1);
            k_nxt       = NB'(lag_r) + NB'(1);
            mac_ctl.clr = 1'b1;
            state_nxt   = S_CRD;
          end
        end
      end
      // Closing beat of the item.
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = fin_kind_r;
          out_last_nxt  = 1'b1;
          out_tdata_nxt = {OUT_PAD_W'(0), tau_r, RHO_W'(0), LAG_W'(0)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      rd_pos_r    <= '0;
      k_r         <= '0;
      lag_r       <= '0;
      var_ph_r    <= 1'b0;
      sbit_r      <= '0;
      qc_r        <= '0;
      tau_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      rd_pos_r    <= rd_pos_nxt;
      k_r         <= k_nxt;
      lag_r       <= lag_nxt;
      var_ph_r    <= var_ph_nxt;
      sbit_r      <= sbit_nxt;
      qc_r        <= qc_nxt;
      tau_r       <= tau_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    p0_r        <= p0_nxt;
    prev_r      <= prev_nxt;
    sum_r       <= sum_nxt;
    nr_r        <= nr_nxt;
    n_r         <= n_nxt;
    cnt_lag_r   <= cnt_lag_nxt;
    lmax_r      <= lmax_nxt;
    var_r       <= var_nxt;
    cmag_r      <= cmag_nxt;
    cneg_r      <= cneg_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    fin_kind_r  <= fin_kind_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Price history memory.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= in_ext[PRICE_BITS-1:0];
    end
    if (hist_re) begin
      hist_q_r <= hist_mem[rd_pos_nxt];
    end
  end

  // Deviation memory, one write port and two read ports.
  always_ff @(posedge clk) begin
    if (dev_we) begin
      dev_mem[k_r[DA_W-1:0]] <= dev_v;
    end
    if (dev_re) begin
      dev_a_q_r <= dev_mem[k_r[DA_W-1:0]];
      dev_b_q_r <= dev_mem[kb[DA_W-1:0]];
    end
  end

  wrac_mac #(
    .MAG_W (MAG_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .a_mag     (mac_a),
    .b_mag     (mac_b),
    .neg       (mac_neg),
    .acc       (acc),
    .last_step (mac_last)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      max_lags_r <= MAX_LAGS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[REG_SEL_BIT])
        REG_WINDOW:   window_r   <= cfg_pwdata[WIN_W-1:0];
        REG_MAX_LAGS: max_lags_r <= cfg_pwdata[LAG_W-1:0];
        default:      window_r   <= window_r;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_paddr[REG_SEL_BIT])
      REG_WINDOW:   cfg_prdata = CFG_DW'(window_r);
      REG_MAX_LAGS: cfg_prdata = CFG_DW'(max_lags_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/wrac_checker.sv -----
// Port-level checker for the windowed return autocorrelation block, with its bind.
module wrac_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [wrac_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [wrac_pkg::KIND_W-1:0]       out_tuser,
  input logic                              out_tlast
);
  import wrac_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result beat changed");

  // One price at a time: the block is busy right after taking a price.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // Only rho beats are not the closing beat of an item.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == KIND_RHO)
    else $error("non-rho beat without tlast");

  // Closing beats carry no lag and no rho; rho beats carry no tau.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_RHO) ? (out_tdata[27:22] == '0 && out_tdata[5:0] != '0)
                                          : (out_tdata[21:0] == '0))
    else $error("result fields inconsistent with kind");

endmodule

bind windowed_return_autocorrelation wrac_checker u_wrac_checker (.*);
